FILE: rtl/core/barometer_raw_compensation_macros.svh
// Assertion macros shared by the barometer compensation checker.
// Expects clk and rst in scope where used.
`ifndef BAROMETER_RAW_COMPENSATION_MACROS_SVH
`define BAROMETER_RAW_COMPENSATION_MACROS_SVH

// implication checked outside reset
`define BPRC_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bprc assertion failed");

// next-cycle implication checked outside reset
`define BPRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bprc assertion failed");

// next-cycle implication that also runs through reset
`define BPRC_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bprc assertion failed");

`endif

FILE: rtl/core/bprc_pkg.sv
// Package for barometer compensation: calibration and side-band types,
// constants and the truncating shift helper. No dependencies.
`default_nettype none

package bprc_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;

  localparam logic [CfgIndexW-1:0] CfgTempCalib   = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgPressCal14  = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgPressCal58  = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgPressCal9   = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgTempLimits  = 3'd4;
  localparam logic [CfgIndexW-1:0] CfgPressLimits = 3'd5;

  localparam logic [39:0] LimitsReset = 40'hFF_FF00_0000;

  localparam logic [31:0] FineOffset  = 32'd64000;
  localparam logic [31:0] AdcSpan     = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] SignBound   = 32'h8000_0000;
  localparam logic [31:0] P1Bias      = 32'd32768;
  localparam logic [31:0] RoundBias   = 32'd128;

  localparam int unsigned DivSteps = 32;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } bprc_calib_t;

  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [1:0]  range_status;
  } bprc_side_t;

  typedef struct packed {
    bprc_side_t side;
    logic       dz;
  } bprc_tag_t;

  // sign-extend a 16-bit calibration word
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide by 2**sh, truncating toward zero
  function automatic logic [31:0] sdiv_pow2(input logic [31:0] x, input int unsigned sh);
    logic [31:0] bias;
    bias = x[31] ? ((32'd1 << sh) - 32'd1) : 32'd0;
    return 32'($signed(x + bias) >>> sh);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/barometer_raw_compensation.sv
// Top level of the barometer raw-sample compensation pipeline.
// Uses bprc_pkg, bprc_comp, bprc_div and bprc_post.
//
// Usage:
//  - Input channel (in_valid/in_ready) takes one word: raw_temp, raw_press.
//  - Output channel (out_valid/out_ready) gives one word per input:
//    temp_centi, fine_temp, pressure_pa, range_status, divisor_zero.
//  - Throughput: one word per cycle while the receiver takes words. The pipe has
//    10 front-end stages, 32 divider stages (one quotient bit each) and 3
//    correction stages including the output register.
//  - The whole pipeline shares one advance enable; when the receiver holds
//    out_ready low with a word waiting, every stage holds and in_ready drops.
//    Nothing is dropped or repeated; in-flight words simply wait.
//  - Configuration: cfg_we writes cfg_data to register cfg_index; unknown
//    indexes are ignored. Write only while the pipe is empty.
//  - Reset (rst, synchronous) clears all valid bits and loads the register
//    reset values: calibration zero, ADC limits min 0 / max 0xFFFF0.
//  - A zero pressure divisor yields pressure_pa = 0 with divisor_zero set.
`default_nettype none

module barometer_raw_compensation
  import bprc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [19:0]          raw_temp,
  input  logic [19:0]          raw_press,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          temp_centi,
  output logic [31:0]          fine_temp,
  output logic [31:0]          pressure_pa,
  output logic [1:0]           range_status,
  output logic                 divisor_zero
);

  // configuration registers
  logic [47:0] temp_calib;
  logic [63:0] press_calib_1_4;
  logic [63:0] press_calib_5_8;
  logic [15:0] press_calib_9;
  logic [39:0] temp_adc_limits;
  logic [39:0] press_adc_limits;

  bprc_calib_t cal;
  logic        en;

  logic        fe_valid;
  logic [31:0] fe_c, fe_div;
  bprc_side_t  fe_side;

  logic        dv_valid;
  logic [31:0] dv_q;
  bprc_tag_t   dv_tag;

  bprc_tag_t   po_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_1_4  <= '0;
      press_calib_5_8  <= '0;
      press_calib_9    <= '0;
      temp_adc_limits  <= LimitsReset;
      press_adc_limits <= LimitsReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTempCalib:   temp_calib       <= cfg_data[47:0];
        CfgPressCal14:  press_calib_1_4  <= cfg_data;
        CfgPressCal58:  press_calib_5_8  <= cfg_data;
        CfgPressCal9:   press_calib_9    <= cfg_data[15:0];
        CfgTempLimits:  temp_adc_limits  <= cfg_data[39:0];
        CfgPressLimits: press_adc_limits <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // unpack the calibration words
  assign cal.t1 = temp_calib[15:0];
  assign cal.t2 = temp_calib[31:16];
  assign cal.t3 = temp_calib[47:32];
  assign cal.p1 = press_calib_1_4[15:0];
  assign cal.p2 = press_calib_1_4[31:16];
  assign cal.p3 = press_calib_1_4[47:32];
  assign cal.p4 = press_calib_1_4[63:48];
  assign cal.p5 = press_calib_5_8[15:0];
  assign cal.p6 = press_calib_5_8[31:16];
  assign cal.p7 = press_calib_5_8[47:32];
  assign cal.p8 = press_calib_5_8[63:48];
  assign cal.p9 = press_calib_9;

  // the pipe advances unless the output register holds an untaken word
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  bprc_comp u_comp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .raw_temp  (raw_temp),
    .raw_press (raw_press),
    .cal       (cal),
    .temp_lim  (temp_adc_limits),
    .press_lim (press_adc_limits),
    .out_valid (fe_valid),
    .out_c     (fe_c),
    .out_div   (fe_div),
    .out_side  (fe_side)
  );

  bprc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .in_c      (fe_c),
    .in_div    (fe_div),
    .in_side   (fe_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_tag   (dv_tag)
  );

  bprc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (dv_valid),
    .in_q      (dv_q),
    .in_tag    (dv_tag),
    .cal       (cal),
    .out_valid (out_valid),
    .out_press (pressure_pa),
    .out_tag   (po_tag)
  );

  assign temp_centi   = po_tag.side.temp_centi;
  assign fine_temp    = po_tag.side.fine_temp;
  assign range_status = po_tag.side.range_status;
  assign divisor_zero = po_tag.dz;

endmodule

`default_nettype wire

FILE: rtl/core/bprc_comp.sv
// Ten-stage front end: temperature terms, fine term and pressure divisor
// and dividend. Depends on bprc_pkg.
`default_nettype none

module bprc_comp
  import bprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [19:0] raw_temp,
  input  logic [19:0] raw_press,
  input  bprc_calib_t cal,
  input  logic [39:0] temp_lim,
  input  logic [39:0] press_lim,
  output logic        out_valid,
  output logic [31:0] out_c,
  output logic [31:0] out_div,
  output bprc_side_t  out_side
);

  logic [10:1] vld;

  logic [19:0] s1_ut, s1_up;
  logic [1:0]  s1_st;
  logic [19:0] s2_up, s3_up, s4_up, s5_up, s6_up, s7_up, s8_up;
  logic [1:0]  s2_st, s3_st, s4_st;
  logic [31:0] s2_ta, s2_dsq;
  logic [31:0] s3_ta, s3_tb;
  logic [31:0] s4_fine;
  bprc_side_t  s5_side, s6_side, s7_side, s8_side, s9_side, s10_side;
  logic [31:0] s5_v1;
  logic [31:0] s6_sq, s6_v1p5, s6_p2v1;
  logic [31:0] s7_m6, s7_m3, s7_v1p5, s7_p2v1;
  logic [31:0] s8_v2, s8_a;
  logic [31:0] s9_m1, s9_cd;
  logic [31:0] s10_div, s10_c;

  logic        t_out, p_out;
  logic [31:0] pa, dd, fine_c, q_c, v2_c, a_c;

  // raw <= min or raw >= max flags out of range
  assign t_out = (raw_temp <= temp_lim[19:0]) || (raw_temp >= temp_lim[39:20]);
  assign p_out = (raw_press <= press_lim[19:0]) || (raw_press >= press_lim[39:20]);

  assign pa     = {15'd0, s1_ut[19:3]} - {15'd0, cal.t1, 1'b0};
  assign dd     = {16'd0, s1_ut[19:4]} - {16'd0, cal.t1};
  assign fine_c = s3_ta + sdiv_pow2(s3_tb, 14);
  assign q_c    = sdiv_pow2(s5_v1, 2);
  assign v2_c   = sdiv_pow2(s7_m6 + {s7_v1p5[30:0], 1'b0}, 2) + {cal.p4, 16'd0};
  assign a_c    = sdiv_pow2(sdiv_pow2(s7_m3, 3) + sdiv_pow2(s7_p2v1, 1), 18);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[9:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ut <= raw_temp;
      s1_up <= raw_press;
      s1_st <= {p_out, t_out};

      s2_ta  <= pa * sx16(cal.t2);
      s2_dsq <= dd * dd;
      s2_up  <= s1_up;
      s2_st  <= s1_st;

      s3_ta <= sdiv_pow2(s2_ta, 11);
      s3_tb <= sdiv_pow2(s2_dsq, 12) * sx16(cal.t3);
      s3_up <= s2_up;
      s3_st <= s2_st;

      s4_fine <= fine_c;
      s4_up   <= s3_up;
      s4_st   <= s3_st;

      s5_side.temp_centi   <= sdiv_pow2(s4_fine + {s4_fine[29:0], 2'b00} + RoundBias, 8);
      s5_side.fine_temp    <= s4_fine;
      s5_side.range_status <= s4_st;
      s5_v1                <= sdiv_pow2(s4_fine, 1) - FineOffset;
      s5_up                <= s4_up;

      s6_sq   <= q_c * q_c;
      s6_v1p5 <= s5_v1 * sx16(cal.p5);
      s6_p2v1 <= sx16(cal.p2) * s5_v1;
      s6_side <= s5_side;
      s6_up   <= s5_up;

      s7_m6   <= sdiv_pow2(s6_sq, 11) * sx16(cal.p6);
      s7_m3   <= sx16(cal.p3) * sdiv_pow2(s6_sq, 13);
      s7_v1p5 <= s6_v1p5;
      s7_p2v1 <= s6_p2v1;
      s7_side <= s6_side;
      s7_up   <= s6_up;

      s8_v2   <= v2_c;
      s8_a    <= a_c;
      s8_side <= s7_side;
      s8_up   <= s7_up;

      s9_m1   <= (s8_a + P1Bias) * {16'd0, cal.p1};
      s9_cd   <= (AdcSpan - {12'd0, s8_up}) - sdiv_pow2(s8_v2, 12);
      s9_side <= s8_side;

      s10_div  <= sdiv_pow2(s9_m1, 15);
      s10_c    <= s9_cd * PressScale;
      s10_side <= s9_side;
    end
  end

  assign out_valid = vld[10];
  assign out_c     = s10_c;
  assign out_div   = s10_div;
  assign out_side  = s10_side;

endmodule

`default_nettype wire

FILE: rtl/core/bprc_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the
// pressure step. Depends on bprc_pkg.
`default_nettype none

module bprc_div
  import bprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_c,
  input  logic [31:0] in_div,
  input  bprc_side_t  in_side,
  output logic        out_valid,
  output logic [31:0] out_q,
  output bprc_tag_t   out_tag
);

  logic        vld_q  [1:DivSteps];
  logic [31:0] rem_q  [1:DivSteps];
  logic [31:0] x_q    [1:DivSteps];
  logic [31:0] dv_q   [1:DivSteps];
  logic        mode_q [1:DivSteps];
  bprc_tag_t   tag_q  [1:DivSteps];

  logic        mode0;
  logic [31:0] x0;
  bprc_tag_t   tag0;

  // large dividends are divided unshifted and the quotient doubled after
  assign mode0    = (in_c >= SignBound);
  assign x0       = mode0 ? in_c : {in_c[30:0], 1'b0};
  assign tag0.side = in_side;
  assign tag0.dz   = (in_div == 32'd0);

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic        v_s, m_s, ge;
    logic [31:0] r_s, x_s, d_s;
    bprc_tag_t   t_s;
    logic [32:0] trial;

    if (i == 0) begin : g_src0
      assign v_s = in_valid;
      assign r_s = 32'd0;
      assign x_s = x0;
      assign d_s = in_div;
      assign m_s = mode0;
      assign t_s = tag0;
    end else begin : g_srcn
      assign v_s = vld_q[i];
      assign r_s = rem_q[i];
      assign x_s = x_q[i];
      assign d_s = dv_q[i];
      assign m_s = mode_q[i];
      assign t_s = tag_q[i];
    end

    assign trial = {r_s, x_s[31]};
    assign ge    = (trial >= {1'b0, d_s});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i+1]  <= ge ? 32'(trial - {1'b0, d_s}) : trial[31:0];
        x_q[i+1]    <= {x_s[30:0], ge};
        dv_q[i+1]   <= d_s;
        mode_q[i+1] <= m_s;
        tag_q[i+1]  <= t_s;
      end
    end
  end

  assign out_valid = vld_q[DivSteps];
  assign out_q     = mode_q[DivSteps] ? {x_q[DivSteps][30:0], 1'b0} : x_q[DivSteps];
  assign out_tag   = tag_q[DivSteps];

endmodule

`default_nettype wire

FILE: rtl/core/bprc_post.sv
// Three-stage pressure correction after the division; last stage is the
// output register. Depends on bprc_pkg.
`default_nettype none

module bprc_post
  import bprc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] in_q,
  input  bprc_tag_t   in_tag,
  input  bprc_calib_t cal,
  output logic        out_valid,
  output logic [31:0] out_press,
  output bprc_tag_t   out_tag
);

  logic [3:1]  vld;
  logic [31:0] s1_e2, s1_cp8, s1_c;
  logic [31:0] s2_pm9, s2_b, s2_c;
  bprc_tag_t   s1_tag, s2_tag;
  logic [31:0] e_c, d_c;

  assign e_c = {3'd0, in_q[31:3]};
  assign d_c = sdiv_pow2(sdiv_pow2(s2_pm9, 12) + s2_b + sx16(cal.p7), 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_e2  <= e_c * e_c;
      s1_cp8 <= {2'd0, in_q[31:2]} * sx16(cal.p8);
      s1_c   <= in_q;
      s1_tag <= in_tag;

      s2_pm9 <= sx16(cal.p9) * {13'd0, s1_e2[31:13]};
      s2_b   <= sdiv_pow2(s1_cp8, 13);
      s2_c   <= s1_c;
      s2_tag <= s1_tag;

      out_press <= s2_tag.dz ? 32'd0 : s2_c + d_c;
      out_tag   <= s2_tag;
    end
  end

  assign out_valid = vld[3];

endmodule

`default_nettype wire

FILE: rtl/core/bprc_checker.sv
// Port-level checks for barometer_raw_compensation, attached by bind.
// Uses barometer_raw_compensation_macros.svh.
`default_nettype none

`include "barometer_raw_compensation_macros.svh"

module bprc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] temp_centi,
  input wire logic [31:0] fine_temp,
  input wire logic [31:0] pressure_pa,
  input wire logic [1:0]  range_status,
  input wire logic        divisor_zero
);

  `BPRC_ASSERT_IMPL(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready))
  `BPRC_ASSERT_IMPL(a_dz_zero_press, out_valid && divisor_zero, pressure_pa == 32'd0)
  `BPRC_ASSERT_RST(a_reset_empty, rst, !out_valid)
  `BPRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(pressure_pa) && $stable(fine_temp) && $stable(temp_centi))

endmodule

bind barometer_raw_compensation bprc_checker u_bprc_checker (.*);

`default_nettype wire

FILE: tb/tb_barometer_raw_compensation.sv
// Self-checking testbench for barometer_raw_compensation: random and directed
// raw sample words, checked field by field against an in-bench predictor.
// Depends on bprc_pkg and the barometer_raw_compensation RTL only.
`default_nettype none

module tb_barometer_raw_compensation
  import bprc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // one compensated output word
  typedef struct {
    bit [31:0] temp_centi;
    bit [31:0] fine_temp;
    bit [31:0] pressure_pa;
    bit [1:0]  range_status;
    bit        divisor_zero;
  } comp_word_t;

  // Scoreboard: keeps its own register copy, predicts each accepted word and
  // checks output words in order.
  class comp_scoreboard;
    bit [63:0]  regs [6];
    comp_word_t pending [$];
    int         errors;
    int         checked;
    int         dz_seen;
    int         big_seen;
    int         range_seen [4];

    function new();
      regs[0] = '0; regs[1] = '0; regs[2] = '0; regs[3] = '0;
      regs[4] = 64'(LimitsReset);
      regs[5] = 64'(LimitsReset);
    endfunction

    function void write_reg(bit [2:0] idx, bit [63:0] val);
      case (idx)
        CfgTempCalib:   regs[0] = {16'h0, val[47:0]};
        CfgPressCal14:  regs[1] = val;
        CfgPressCal58:  regs[2] = val;
        CfgPressCal9:   regs[3] = {48'h0, val[15:0]};
        CfgTempLimits:  regs[4] = {24'h0, val[39:0]};
        CfgPressLimits: regs[5] = {24'h0, val[39:0]};
        default: ;
      endcase
    endfunction

    static function longint w32(longint x);
      int t;
      t = x[31:0];
      return t;
    endfunction

    static function longint s16(bit [15:0] v);
      shortint s;
      s = v;
      return s;
    endfunction

    static function bit outside_lim(bit [19:0] raw, bit [39:0] lim);
      return raw <= lim[19:0] || raw >= lim[39:20];
    endfunction

    function comp_word_t compensate(bit [19:0] rt, bit [19:0] rp);
      comp_word_t r;
      longint ut, up, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint a, b, d, q, sq, fine, v1, v2, ue, uq;
      bit [31:0] c, dv, e, e2;
      ut = rt; up = rp;
      t1 = regs[0][15:0];
      t2 = s16(regs[0][31:16]);
      t3 = s16(regs[0][47:32]);
      p1 = regs[1][15:0];
      p2 = s16(regs[1][31:16]);
      p3 = s16(regs[1][47:32]);
      p4 = s16(regs[1][63:48]);
      p5 = s16(regs[2][15:0]);
      p6 = s16(regs[2][31:16]);
      p7 = s16(regs[2][47:32]);
      p8 = s16(regs[2][63:48]);
      p9 = s16(regs[3][15:0]);

      // temperature, fine term first
      a = w32(w32((ut / 8 - t1 * 2) * t2) / 2048);
      d = ut / 16 - t1;
      b = w32(w32((w32(d * d) / 4096) * t3) / 16384);
      fine = w32(a + b);
      r.fine_temp = fine[31:0];
      a = w32(w32(fine * 5) + 128) / 256;
      r.temp_centi = a[31:0];

      // pressure divisor and numerator
      v1 = w32(fine / 2 - 64000);
      q = v1 / 4;
      sq = w32(q * q);
      v2 = w32((sq / 2048) * p6);
      v2 = w32(v2 + w32(w32(v1 * p5) * 2));
      v2 = w32(v2 / 4 + w32(p4 * 65536));
      a = w32(w32(p3 * (sq / 8192)) / 8 + w32(p2 * v1) / 2) / 262144;
      v1 = w32(w32(32768 + a) * p1) / 32768;
      a = w32(w32((1048576 - up) - v2 / 4096) * 3125);
      c = a[31:0];

      r.divisor_zero = (v1 == 0);
      if (v1 != 0) begin
        dv = v1[31:0];
        if (c < 32'h8000_0000) begin
          c = (c << 1) / dv;
        end else begin
          c = (c / dv) * 2;
          big_seen++;
        end
        e = c / 8;
        e2 = e * e;
        ue = e2 / 8192;
        uq = c / 4;
        a = w32(p9 * ue) / 4096;
        b = w32(uq * p8) / 8192;
        d = w32(w32(a + b) + p7) / 16;
        a = w32(w32(longint'(int'(c))) + d);
        c = a[31:0];
      end else begin
        c = '0;
      end
      r.pressure_pa = c;
      r.range_status = {outside_lim(rp, regs[5][39:0]), outside_lim(rt, regs[4][39:0])};
      return r;
    endfunction

    function void note_input(bit [19:0] rt, bit [19:0] rp);
      comp_word_t r;
      r = compensate(rt, rp);
      dz_seen += r.divisor_zero;
      range_seen[r.range_status]++;
      pending.push_back(r);
    endfunction

    function void check_output(comp_word_t got);
      comp_word_t exp_w;
      if (pending.size() == 0) begin
        $error("output word with nothing expected");
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      checked++;
      if (got.temp_centi !== exp_w.temp_centi) begin
        $error("temp_centi: expected %0h got %0h", exp_w.temp_centi, got.temp_centi);
        errors++;
      end
      if (got.fine_temp !== exp_w.fine_temp) begin
        $error("fine_temp: expected %0h got %0h", exp_w.fine_temp, got.fine_temp);
        errors++;
      end
      if (got.pressure_pa !== exp_w.pressure_pa) begin
        $error("pressure_pa: expected %0h got %0h", exp_w.pressure_pa, got.pressure_pa);
        errors++;
      end
      if (got.range_status !== exp_w.range_status) begin
        $error("range_status: expected %0h got %0h", exp_w.range_status,
               got.range_status);
        errors++;
      end
      if (got.divisor_zero !== exp_w.divisor_zero) begin
        $error("divisor_zero: expected %0h got %0h", exp_w.divisor_zero,
               got.divisor_zero);
        errors++;
      end
    endfunction
  endclass

  localparam int CycleLimit = 600000;
  localparam int DrainWait  = 60;      // longer than the pipeline latency
  localparam int HoldCycles = 300;     // long receiver hold-off

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [19:0]          raw_temp;
  logic [19:0]          raw_press;
  logic                 out_valid;
  logic                 out_ready;
  logic [31:0]          temp_centi;
  logic [31:0]          fine_temp;
  logic [31:0]          pressure_pa;
  logic [1:0]           range_status;
  logic                 divisor_zero;

  comp_scoreboard sb;
  int  cycles;
  bit  hold_req;      // asks the receiver for one long hold-off
  bit  rcv_steady;    // receiver always ready
  bit  snd_steady;    // sender never idles
  int  sent;
  int  phases;

  barometer_raw_compensation u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .raw_temp(raw_temp), .raw_press(raw_press),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_centi(temp_centi), .fine_temp(fine_temp), .pressure_pa(pressure_pa),
    .range_status(range_status), .divisor_zero(divisor_zero)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // output monitor: a word moves when valid and ready are both high
  always @(posedge clk) begin
    comp_word_t got;
    if (!rst && out_valid && out_ready) begin
      got.temp_centi   = temp_centi;
      got.fine_temp    = fine_temp;
      got.pressure_pa  = pressure_pa;
      got.range_status = range_status;
      got.divisor_zero = divisor_zero;
      sb.check_output(got);
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random back-pressure, plus one long hold when asked
  initial begin
    int gap;
    int hold_left;
    bit held;
    gap = 0;
    hold_left = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        hold_left = HoldCycles;
        held = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rcv_steady) begin
        out_ready <= 1'b1;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        gap = pick_gap();
        out_ready <= (gap == 0);
        if (gap > 0) gap--;
      end
    end
  end

  task automatic cfg_write(bit [2:0] idx, bit [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // offer one sample word, hold it until taken, then idle for a random gap, if any
  task automatic send_word(bit [19:0] rt, bit [19:0] rp);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    raw_temp  <= rt;
    raw_press <= rp;
    do @(posedge clk); while (!in_ready);
    sb.note_input(rt, rp);
    sent++;
    gap = snd_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // let every expected word come back, then give the pipe time to settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic set_calib(bit [15:0] t1, bit [15:0] t2, bit [15:0] t3,
                           bit [63:0] p14, bit [63:0] p58, bit [15:0] p9);
    cfg_write(CfgTempCalib, {16'h0, t3, t2, t1});
    cfg_write(CfgPressCal14, p14);
    cfg_write(CfgPressCal58, p58);
    cfg_write(CfgPressCal9, {48'h0, p9});
  endtask

  task automatic set_limits(bit [19:0] tlo, bit [19:0] thi, bit [19:0] plo,
                            bit [19:0] phi);
    cfg_write(CfgTempLimits, {24'h0, thi, tlo});
    cfg_write(CfgPressLimits, {24'h0, phi, plo});
  endtask

  // typical datasheet-like coefficients
  task automatic stock_calib();
    set_calib(16'd27504, 16'd26435, -16'sd1000,
              {16'd2855, 16'd3024, -16'sd10685, 16'd36477},
              {-16'sd14600, 16'd15500, -16'sd7, 16'd140}, 16'd6000);
  endtask

  // raw values: half anywhere, half in the usual conversion band
  function automatic bit [19:0] pick_raw();
    if ($urandom_range(0, 1)) return 20'($urandom);
    return 20'($urandom_range(300000, 600000));
  endfunction

  initial begin
    bit [19:0] lo, hi;
    sb = new();
    hold_req = 1'b0;
    rcv_steady = 1'b0;
    snd_steady = 1'b0;
    sent = 0;
    phases = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    raw_temp = '0;
    raw_press = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: P1 is zero, so every word hits the zero divisor
    send_word(20'h00000, 20'h00000);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'hFFFF0, 20'hFFFEF);
    drain();

    // stock coefficients, limit edges and raw extremes
    stock_calib();
    set_limits(20'h10000, 20'hF0000, 20'h10000, 20'hF0000);
    cfg_write(3'd6, '1);        // unmapped indexes, ignored
    cfg_write(3'd7, '1);
    send_word(20'd519888, 20'd415148);
    send_word(20'h10000, 20'h10001);
    send_word(20'h10001, 20'h10000);
    send_word(20'hEFFFF, 20'hF0000);
    send_word(20'hF0000, 20'hEFFFF);
    send_word(20'h00000, 20'hFFFFF);
    send_word(20'hFFFFF, 20'h00000);
    send_word(20'h55555, 20'hAAAAA);
    send_word(20'hAAAAA, 20'h55555);
    drain();

    // extreme coefficients and limits
    set_calib(16'hFFFF, 16'h7FFF, 16'h8000, '1, {4{16'h7FFF}}, 16'h8000);
    set_limits(20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h00000);
    send_word(20'h00000, 20'h00000);
    send_word(20'hFFFFF, 20'hFFFFF);
    send_word(20'h80000, 20'h7FFFF);
    drain();
    set_calib(16'h0000, 16'h8000, 16'h7FFF, {{3{16'h8000}}, 16'hFFFF},
              {4{16'h8000}}, 16'h7FFF);
    send_word(20'h00000, 20'hFFFFF);
    send_word(20'hFFFFF, 20'h00000);
    drain();

    // random phases with fresh coefficients and limits each time
    for (int ph = 0; ph < 8; ph++) begin
      phases++;
      case (ph % 4)
        0: stock_calib();
        1: set_calib(16'($urandom), 16'($urandom), 16'($urandom),
                     {$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
        2: set_calib(16'($urandom_range(20000, 40000)), 16'($urandom_range(0, 30000)),
                     -16'($urandom_range(0, 2000)),
                     {16'($urandom_range(0, 4000)), 16'($urandom_range(0, 4000)),
                      -16'($urandom_range(5000, 15000)), 16'($urandom_range(20000, 40000))},
                     {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                     16'($urandom));
        default: set_calib(16'($urandom), 16'($urandom), 16'($urandom),
                           {$urandom, 16'($urandom), 16'h0000}, // P1 zero: dz path
                           {$urandom, $urandom}, 16'($urandom));
      endcase
      lo = 20'($urandom);
      hi = 20'($urandom);
      if (ph == 7) begin
        lo = 20'h00000;
        hi = 20'hFFFFF;
      end
      set_limits(lo < hi ? lo : hi, lo < hi ? hi : lo, 20'($urandom), 20'($urandom));

      rcv_steady = (ph == 2);
      snd_steady = (ph == 2 || ph == 5);
      // fill the pipe against a stalled receiver once
      hold_req = (ph == 5);
      for (int i = 0; i < 235; i++) send_word(pick_raw(), pick_raw());
      drain();
    end
    rcv_steady = 1'b0;
    snd_steady = 1'b0;
    hold_req = 1'b0;

    $display("%0d words sent over %0d random phases, %0d checked", sent, phases,
             sb.checked);
    $display("zero divisor %0d, wide numerator %0d, range codes %0d/%0d/%0d/%0d",
             sb.dz_seen, sb.big_seen, sb.range_seen[0], sb.range_seen[1],
             sb.range_seen[2], sb.range_seen[3]);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
